FILE: src/two_level_io_request_scheduler_assert.svh
`ifndef TWO_LEVEL_IO_REQUEST_SCHEDULER_ASSERT_SVH
`define TWO_LEVEL_IO_REQUEST_SCHEDULER_ASSERT_SVH

// Check a same-cycle property on the top-level clock and reset.
`define TLRS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define TLRS_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: src/tlrs_pkg.sv
package tlrs_pkg;

  localparam int ENTRIES   = 32;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int K_W       = $clog2(ENTRIES + 1);
  localparam int HANDLES   = 256;
  localparam int HDL_W     = $clog2(HANDLES);
  localparam int RUN_SLOTS = 32;
  localparam int RUN_W     = $clog2(RUN_SLOTS);
  localparam int ID_W      = 31;
  localparam int BATCH_W   = 6;
  localparam int IN_W      = 216;
  localparam int OUT_W     = 200;
  localparam int ENT_W     = 160;

  localparam logic [ID_W-1:0]    ID_TOP      = {ID_W{1'b1}};
  localparam logic [BATCH_W-1:0] BATCH_RESET = 6'd5;
  localparam logic [BATCH_W-1:0] BATCH_MAX   = 6'd32;

  // Entry pointer: top bit marks null
  typedef logic [IDX_W:0] ptr_t;
  localparam ptr_t NIL_PTR = {1'b1, {IDX_W{1'b0}}};

  typedef enum logic [1:0] {
    OP_SUBMIT   = 2'd0,
    OP_CANCEL   = 2'd1,
    OP_DISPATCH = 2'd2,
    OP_COMPLETE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED      = 3'd0,
    ST_REFUSED       = 3'd1,
    ST_CANCELLED     = 3'd2,
    ST_NOT_CANCELLED = 3'd3,
    ST_DISPATCHED    = 3'd4,
    ST_EMPTY         = 3'd5
  } st_e;

  typedef enum logic [3:0] {
    S_IDLE, S_SUB_FIND, S_SUB_TOP, S_GI_WALK, S_SI_RD, S_SI_CMP, S_GW_WALK,
    S_CN_WAIT, S_CN_TOP, S_CN_SUB, S_CP_WAIT, S_CP_DROP, S_RESP,
    S_D_START, S_D_RD, S_D_EM
  } state_e;

  typedef enum logic [3:0] {
    A_NOP, A_IDLE, A_SUB_FIND, A_SUB_TOP, A_GI_WALK, A_SI_CMP, A_GW_WALK,
    A_CN_TOP, A_CN_SUB, A_CP_DROP, A_RESP, A_D_START, A_D_EM
  } act_e;

  typedef struct packed {
    act_e act;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic top_nil;
    logic gi_front;
    logic rp_gt;
    logic gi_adv;
    logic si_ins;
    logic gw_hit;
    logic top_hit;
    logic cur_nil;
    logic cur_hit;
    logic head_nil;
    logic out_free;
    logic d_more;
  } stat_t;

endpackage

FILE: src/tlrs_ram.sv
module tlrs_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: src/tlrs_ctrl.sv
module tlrs_ctrl import tlrs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  input  logic [1:0] in_op_i,
  input  stat_t      stat_i,
  output cmd_t       cmd_o,
  output logic       s_ready_o
);

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          case (op_e'(in_op_i))
            OP_SUBMIT:   state_d = S_SUB_FIND;
            OP_CANCEL:   state_d = S_CN_WAIT;
            OP_DISPATCH: state_d = S_D_START;
            default:     state_d = S_CP_WAIT;
          endcase
        end
      end
      S_SUB_FIND: state_d = stat_i.full ? S_RESP : S_SUB_TOP;
      S_SUB_TOP: begin
        if (stat_i.top_nil) state_d = stat_i.gi_front ? S_RESP : S_GI_WALK;
        else if (stat_i.rp_gt) state_d = S_GW_WALK;
        else state_d = S_SI_RD;
      end
      S_GI_WALK: state_d = stat_i.gi_adv ? S_GI_WALK : S_RESP;
      S_SI_RD:   state_d = S_SI_CMP;
      S_SI_CMP:  state_d = stat_i.si_ins ? S_RESP : S_SI_RD;
      S_GW_WALK: state_d = stat_i.gw_hit ? S_RESP : S_GW_WALK;
      S_CN_WAIT: state_d = S_CN_TOP;
      S_CN_TOP: begin
        if (stat_i.top_nil) state_d = S_RESP;
        else if (stat_i.top_hit) state_d = S_GW_WALK;
        else state_d = S_CN_SUB;
      end
      S_CN_SUB:  state_d = (stat_i.cur_nil || stat_i.cur_hit) ? S_RESP : S_CN_SUB;
      S_CP_WAIT: state_d = S_CP_DROP;
      S_CP_DROP: state_d = S_IDLE;
      S_RESP:    state_d = stat_i.out_free ? S_IDLE : S_RESP;
      S_D_START: begin
        if (!stat_i.head_nil) state_d = S_D_RD;
        else if (stat_i.out_free) state_d = S_IDLE;
      end
      S_D_RD: state_d = S_D_EM;
      S_D_EM: begin
        if (stat_i.out_free) state_d = stat_i.d_more ? S_D_RD : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    s_ready_o = (state_q == S_IDLE);
    cmd_o.load = s_ready_o && s_valid_i;
    case (state_q)
      S_IDLE:     cmd_o.act = A_IDLE;
      S_SUB_FIND: cmd_o.act = A_SUB_FIND;
      S_SUB_TOP:  cmd_o.act = A_SUB_TOP;
      S_GI_WALK:  cmd_o.act = A_GI_WALK;
      S_SI_CMP:   cmd_o.act = A_SI_CMP;
      S_GW_WALK:  cmd_o.act = A_GW_WALK;
      S_CN_TOP:   cmd_o.act = A_CN_TOP;
      S_CN_SUB:   cmd_o.act = A_CN_SUB;
      S_CP_DROP:  cmd_o.act = A_CP_DROP;
      S_RESP:     cmd_o.act = A_RESP;
      S_D_START:  cmd_o.act = A_D_START;
      S_D_EM:     cmd_o.act = A_D_EM;
      default:    cmd_o.act = A_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: src/tlrs_dp.sv
module tlrs_dp import tlrs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  input  logic [1:0]          in_op_i,
  input  logic [IN_W-1:0]     in_data_i,
  input  logic                cfg_we_i,
  input  logic [BATCH_W-1:0]  cfg_wdata_i,
  input  logic                m_ready_i,
  output stat_t               stat_o,
  output logic                m_valid_o,
  output logic [2:0]          m_status_o,
  output logic [ID_W-1:0]     m_id_o,
  output logic [7:0]          m_handle_o,
  output logic [63:0]         m_offset_o,
  output logic [31:0]         m_count_o,
  output logic                m_write_o,
  output logic [63:0]         m_buffer_o,
  output logic                m_last_o
);

  // Latched item
  op_e              op_q;
  logic [HDL_W-1:0] h_q;
  logic [7:0]       gp_q, rp_q;
  logic [63:0]      off_q, buf_q;
  logic [31:0]      cnt_q;
  logic             wr_q;
  logic [ID_W-1:0]  tid_q;

  logic [BATCH_W-1:0] batch_q, batch_eff;

  // Entry store: links and small attributes in flops, wide fields in RAM
  logic             busy_q [ENTRIES];
  ptr_t             link_q [ENTRIES];
  ptr_t             subh_q [ENTRIES];
  logic [7:0]       ehdl_q [ENTRIES];
  logic [7:0]       egp_q  [ENTRIES];
  logic [7:0]       erp_q  [ENTRIES];
  logic             ewr_q  [ENTRIES];
  logic [ID_W-1:0]  eid_q  [ENTRIES];

  ptr_t head_q, cur_q, prev_q, top_q, tgt_q, nv_q, nt_q, e_q;
  logic free_q, insub_q;
  logic [K_W-1:0]  k_q, k1;
  logic [ID_W-1:0] ctr_q, resp_id_q, id_nxt;
  st_e             resp_st_q;

  // Running set
  logic [ID_W-1:0]      rid_q [RUN_SLOTS];
  logic                 rvld_q [RUN_SLOTS];
  logic [RUN_SLOTS-1:0] match_q;

  // Per-handle top entry
  logic [HANDLES-1:0] slot_vld_q;
  ptr_t               slot_rdata, slot_wdata;
  logic               slot_we;

  logic [ENT_W-1:0] ent_rdata;
  logic             ent_we;
  logic [63:0]      ent_off, ent_buf;
  logic [31:0]      ent_cnt;

  logic [IDX_W-1:0] ci, ei, pi, tpi, tgi, ti, si, hi, free_idx;
  logic [RUN_W-1:0] run_free_idx, drop_idx;
  logic             full, run_full, drop_any;
  ptr_t             top_w, lnk_c, next_s, nt;
  logic             top_nil, cur_nil, head_nil, gi_front, gi_adv, rp_gt, si_ins;
  logic             gw_hit, top_hit, cur_hit, go_sub, go_grp, d_more, out_free, load_out;

  assign ci  = cur_q[IDX_W-1:0];
  assign ei  = e_q[IDX_W-1:0];
  assign pi  = prev_q[IDX_W-1:0];
  assign tpi = top_q[IDX_W-1:0];
  assign tgi = tgt_q[IDX_W-1:0];
  assign hi  = head_q[IDX_W-1:0];

  assign top_w   = slot_vld_q[h_q] ? slot_rdata : NIL_PTR;
  assign ti      = top_w[IDX_W-1:0];
  assign top_nil = top_w[IDX_W];
  assign si      = subh_q[ti][IDX_W-1:0];
  assign cur_nil = cur_q[IDX_W];
  assign head_nil = head_q[IDX_W];
  assign lnk_c   = link_q[ci];

  assign ent_off = ent_rdata[63:0];
  assign ent_buf = ent_rdata[127:64];
  assign ent_cnt = ent_rdata[159:128];

  assign id_nxt   = ctr_q + ID_W'(1);
  assign gi_front = head_nil || (gp_q > egp_q[hi]);
  assign gi_adv   = !lnk_c[IDX_W] && (gp_q <= egp_q[lnk_c[IDX_W-1:0]]);
  assign rp_gt    = rp_q > erp_q[ti];
  assign si_ins   = cur_nil || ((rp_q != erp_q[ci]) ? (rp_q > erp_q[ci]) : (off_q < ent_off));
  assign gw_hit   = (cur_q == tgt_q);
  assign top_hit  = (eid_q[ti] == tid_q);
  assign cur_hit  = (eid_q[ci] == tid_q);

  // Continue a dispatch into the sub-queue or the next group
  assign k1     = k_q + K_W'(1);
  assign next_s = insub_q ? lnk_c : subh_q[ci];
  assign nt     = insub_q ? nt_q : lnk_c;
  assign go_sub = !next_s[IDX_W] && (k1 < K_W'(ENTRIES));
  assign go_grp = !nt[IDX_W] && (k1 < K_W'(batch_eff));
  assign d_more = go_sub || go_grp;

  assign out_free = !m_valid_o || m_ready_i;
  assign load_out = out_free && ((cmd_i.act == A_RESP) || (cmd_i.act == A_D_EM) ||
                                 ((cmd_i.act == A_D_START) && head_nil));

  always_comb begin
    if (batch_q == '0) batch_eff = BATCH_W'(1);
    else if (batch_q > BATCH_MAX) batch_eff = BATCH_MAX;
    else batch_eff = batch_q;
  end

  // Lowest free entry, lowest free running slot, lowest matching slot
  always_comb begin
    full = 1'b1;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        full = 1'b0;
        free_idx = IDX_W'(i);
      end
    end
    run_full = 1'b1;
    run_free_idx = '0;
    drop_any = 1'b0;
    drop_idx = '0;
    for (int i = RUN_SLOTS - 1; i >= 0; i--) begin
      if (!rvld_q[i]) begin
        run_full = 1'b0;
        run_free_idx = RUN_W'(i);
      end
      if (match_q[i]) begin
        drop_any = 1'b1;
        drop_idx = RUN_W'(i);
      end
    end
  end

  // Slot table writes
  always_comb begin
    slot_we = 1'b0;
    slot_wdata = e_q;
    if (cmd_i.act == A_SUB_TOP) begin
      slot_we = top_nil || rp_gt;
    end else if (cmd_i.act == A_CN_TOP) begin
      slot_we = !top_nil && top_hit && !subh_q[ti][IDX_W];
      slot_wdata = subh_q[ti];
    end
  end

  assign ent_we = (cmd_i.act == A_SUB_FIND) && !full;

  tlrs_ram #(.Width(ENT_W), .Depth(ENTRIES)) u_ent_ram (
    .clk_i  (clk_i),
    .we_i   (ent_we),
    .waddr_i(free_idx),
    .wdata_i({cnt_q, buf_q, off_q}),
    .raddr_i(ci),
    .rdata_o(ent_rdata)
  );

  tlrs_ram #(.Width(IDX_W + 1), .Depth(HANDLES)) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .waddr_i(h_q),
    .wdata_i(slot_wdata),
    .raddr_i(h_q),
    .rdata_o(slot_rdata)
  );

  // List structure and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_q <= BATCH_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
        busy_q[i] <= 1'b0;
        link_q[i] <= NIL_PTR;
        subh_q[i] <= NIL_PTR;
      end
      for (int i = 0; i < RUN_SLOTS; i++) begin
        rvld_q[i] <= 1'b0;
      end
      match_q    <= '0;
      slot_vld_q <= '0;
      head_q     <= NIL_PTR;
      cur_q      <= NIL_PTR;
      prev_q     <= NIL_PTR;
      top_q      <= NIL_PTR;
      tgt_q      <= NIL_PTR;
      nv_q       <= NIL_PTR;
      nt_q       <= NIL_PTR;
      e_q        <= NIL_PTR;
      free_q     <= 1'b0;
      insub_q    <= 1'b0;
      k_q        <= '0;
      ctr_q      <= '0;
      m_valid_o  <= 1'b0;
    end else begin
      if (cfg_we_i) batch_q <= cfg_wdata_i;
      for (int i = 0; i < RUN_SLOTS; i++) begin
        match_q[i] <= rvld_q[i] && (rid_q[i] == tid_q);
      end
      if (slot_we) slot_vld_q[h_q] <= 1'b1;
      if (load_out) m_valid_o <= 1'b1;
      else if (m_ready_i) m_valid_o <= 1'b0;

      case (cmd_i.act)
        A_IDLE: begin
          if (cmd_i.load) k_q <= '0;
        end
        A_SUB_FIND: begin
          if (!full) begin
            e_q <= {1'b0, free_idx};
            ctr_q <= (id_nxt == ID_TOP) ? '0 : id_nxt;
            busy_q[free_idx] <= 1'b1;
            link_q[free_idx] <= NIL_PTR;
            subh_q[free_idx] <= NIL_PTR;
          end
        end
        A_SUB_TOP: begin
          top_q <= top_w;
          if (top_nil) begin
            if (gi_front) begin
              link_q[ei] <= head_q;
              head_q <= e_q;
            end else begin
              cur_q <= head_q;
            end
          end else if (rp_gt) begin
            // New request takes over the top; old top heads the sub-queue
            link_q[ei] <= link_q[ti];
            link_q[ti] <= subh_q[ti];
            subh_q[ei] <= top_w;
            subh_q[ti] <= NIL_PTR;
            tgt_q <= top_w;
            nv_q <= e_q;
            cur_q <= head_q;
            prev_q <= NIL_PTR;
            free_q <= 1'b0;
          end else begin
            prev_q <= NIL_PTR;
            cur_q <= subh_q[ti];
          end
        end
        A_GI_WALK: begin
          if (gi_adv) begin
            cur_q <= lnk_c;
          end else begin
            link_q[ei] <= lnk_c;
            link_q[ci] <= e_q;
          end
        end
        A_SI_CMP: begin
          if (si_ins) begin
            link_q[ei] <= cur_q;
            if (prev_q[IDX_W]) subh_q[tpi] <= e_q;
            else link_q[pi] <= e_q;
          end else begin
            prev_q <= cur_q;
            cur_q <= lnk_c;
          end
        end
        A_GW_WALK: begin
          if (gw_hit) begin
            if (prev_q[IDX_W]) head_q <= nv_q;
            else link_q[pi] <= nv_q;
            if (free_q) begin
              busy_q[tgi] <= 1'b0;
              link_q[tgi] <= NIL_PTR;
              subh_q[tgi] <= NIL_PTR;
            end
          end else begin
            prev_q <= cur_q;
            cur_q <= lnk_c;
          end
        end
        A_CN_TOP: begin
          top_q <= top_w;
          if (!top_nil) begin
            if (top_hit) begin
              tgt_q <= top_w;
              cur_q <= head_q;
              prev_q <= NIL_PTR;
              free_q <= 1'b1;
              if (subh_q[ti][IDX_W]) begin
                slot_vld_q[h_q] <= 1'b0;
                nv_q <= link_q[ti];
              end else begin
                // Promote the sub-queue head into the group list
                subh_q[si] <= link_q[si];
                link_q[si] <= link_q[ti];
                nv_q <= subh_q[ti];
              end
            end else begin
              prev_q <= NIL_PTR;
              cur_q <= subh_q[ti];
            end
          end
        end
        A_CN_SUB: begin
          if (!cur_nil) begin
            if (cur_hit) begin
              if (prev_q[IDX_W]) subh_q[tpi] <= lnk_c;
              else link_q[pi] <= lnk_c;
              busy_q[ci] <= 1'b0;
              link_q[ci] <= NIL_PTR;
              subh_q[ci] <= NIL_PTR;
            end else begin
              prev_q <= cur_q;
              cur_q <= lnk_c;
            end
          end
        end
        A_CP_DROP: begin
          if (drop_any) rvld_q[drop_idx] <= 1'b0;
        end
        A_D_START: begin
          if (!head_nil) begin
            cur_q <= head_q;
            insub_q <= 1'b0;
          end
        end
        A_D_EM: begin
          if (out_free) begin
            if (!insub_q) begin
              slot_vld_q[ehdl_q[ci]] <= 1'b0;
              nt_q <= lnk_c;
            end
            if (!run_full) rvld_q[run_free_idx] <= 1'b1;
            busy_q[ci] <= 1'b0;
            link_q[ci] <= NIL_PTR;
            subh_q[ci] <= NIL_PTR;
            k_q <= k1;
            if (go_sub) begin
              cur_q <= next_s;
              insub_q <= 1'b1;
            end else if (go_grp) begin
              cur_q <= nt;
              insub_q <= 1'b0;
            end else begin
              head_q <= nt;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Item fields, entry attributes, running ids and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_e'(in_op_i);
      h_q   <= in_data_i[7:0];
      gp_q  <= in_data_i[15:8];
      rp_q  <= in_data_i[23:16];
      off_q <= in_data_i[87:24];
      cnt_q <= in_data_i[119:88];
      wr_q  <= in_data_i[120];
      buf_q <= in_data_i[184:121];
      tid_q <= in_data_i[215:185];
    end
    case (cmd_i.act)
      A_SUB_FIND: begin
        if (!full) begin
          resp_st_q <= ST_ACCEPTED;
          resp_id_q <= id_nxt;
          ehdl_q[free_idx] <= h_q;
          egp_q[free_idx]  <= gp_q;
          erp_q[free_idx]  <= rp_q;
          ewr_q[free_idx]  <= wr_q;
          eid_q[free_idx]  <= id_nxt;
        end else begin
          resp_st_q <= ST_REFUSED;
          resp_id_q <= '0;
        end
      end
      A_SUB_TOP: begin
        if (!top_nil && rp_gt) egp_q[ei] <= egp_q[ti];
      end
      A_CN_TOP: begin
        if (!top_nil && top_hit && !subh_q[ti][IDX_W]) egp_q[si] <= egp_q[ti];
      end
      A_D_EM: begin
        if (out_free && !run_full) rid_q[run_free_idx] <= eid_q[ci];
      end
      default: ;
    endcase

    // Load the output register
    if (load_out) begin
      m_status_o <= ST_EMPTY;
      m_id_o     <= '0;
      m_handle_o <= '0;
      m_offset_o <= '0;
      m_count_o  <= '0;
      m_write_o  <= 1'b0;
      m_buffer_o <= '0;
      m_last_o   <= 1'b1;
      if (cmd_i.act == A_RESP) begin
        if (op_q == OP_CANCEL) begin
          m_status_o <= (|match_q) ? ST_NOT_CANCELLED : ST_CANCELLED;
        end else begin
          m_status_o <= resp_st_q;
          m_id_o     <= resp_id_q;
        end
      end else if (cmd_i.act == A_D_EM) begin
        m_status_o <= ST_DISPATCHED;
        m_id_o     <= eid_q[ci];
        m_handle_o <= ehdl_q[ci];
        m_offset_o <= ent_off;
        m_count_o  <= ent_cnt;
        m_write_o  <= ewr_q[ci];
        m_buffer_o <= ent_buf;
        m_last_o   <= !d_more;
      end
    end
  end

  always_comb begin
    stat_o.full     = full;
    stat_o.top_nil  = top_nil;
    stat_o.gi_front = gi_front;
    stat_o.rp_gt    = rp_gt;
    stat_o.gi_adv   = gi_adv;
    stat_o.si_ins   = si_ins;
    stat_o.gw_hit   = gw_hit;
    stat_o.top_hit  = top_hit;
    stat_o.cur_nil  = cur_nil;
    stat_o.cur_hit  = cur_hit;
    stat_o.head_nil = head_nil;
    stat_o.out_free = out_free;
    stat_o.d_more   = d_more;
  end

endmodule

FILE: src/two_level_io_request_scheduler.sv
// Channel  | Direction | Contents
// s_axis   | in        | tuser: op; tdata: request fields
// m_axis   | out       | tuser: status; tdata: result fields; tlast: last
// cfg      | in        | cfg_we_i / cfg_wdata_i: dispatch_batch
//
// One item at a time. Submit: find a free entry (else refuse), read the handle's
// top, then walk the group list to the insert point or the replaced top, or read
// and compare sub-queue positions in turn. Cancel: read the top, then walk the
// group list to a cancelled top, or the sub-queue until the id or its end. Completion
// drops a matching running id. Dispatch reads each emitted request from the
// registered entry RAM. Reset clears list and control registers at once, not entry
// fields; a stalled m_axis holds the current step, and s_axis is ready only in idle.
module two_level_io_request_scheduler import tlrs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // handle, group_priority, request_priority, file_offset, byte_count,
  // is_write, buffer_tag, target_id
  input  logic [IN_W-1:0]     s_axis_tdata,
  // op
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // request_id, out_handle, out_offset, out_count, out_write, out_buffer
  output logic [OUT_W-1:0]    m_axis_tdata,
  // status
  output logic [2:0]          m_axis_tuser,
  output logic                m_axis_tlast,
  input  logic                cfg_we_i,
  input  logic [BATCH_W-1:0]  cfg_wdata_i
);

  cmd_t            cmd;
  stat_t           stat;
  logic [ID_W-1:0] m_id;
  logic [7:0]      m_handle;
  logic [63:0]     m_offset, m_buffer;
  logic [31:0]     m_count;
  logic            m_write;

  tlrs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .in_op_i  (s_axis_tuser),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .s_ready_o(s_axis_tready)
  );

  tlrs_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_op_i    (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .m_ready_i  (m_axis_tready),
    .stat_o     (stat),
    .m_valid_o  (m_axis_tvalid),
    .m_status_o (m_axis_tuser),
    .m_id_o     (m_id),
    .m_handle_o (m_handle),
    .m_offset_o (m_offset),
    .m_count_o  (m_count),
    .m_write_o  (m_write),
    .m_buffer_o (m_buffer),
    .m_last_o   (m_axis_tlast)
  );

  // Pack result fields, first field lowest
  assign m_axis_tdata = {m_buffer, m_write, m_count, m_offset, m_handle, m_id};

  `include "two_level_io_request_scheduler_assert.svh"

  `TLRS_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "accepted item did not start work")
  `TLRS_ASSERT(a_no_accept_mid_burst, !(m_axis_tvalid && !m_axis_tlast && s_axis_tready), "ready while a dispatch burst is open")

endmodule

FILE: sim/two_level_io_request_scheduler_tb.sv
module two_level_io_request_scheduler_tb;
  import tlrs_pkg::*;

  localparam int NONE      = -1;
  localparam int MAX_CYC   = 1000000;
  localparam int SETTLE    = 200;

  typedef struct {
    st_e         status;
    logic [30:0] id;
    logic [7:0]  hdl;
    logic [63:0] off;
    logic [31:0] cnt;
    logic        wr;
    logic [63:0] buff;
    logic        last;
  } sched_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [IN_W-1:0]     s_axis_tdata;
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OUT_W-1:0]    m_axis_tdata;
  logic [2:0]          m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_we_i;
  logic [BATCH_W-1:0]  cfg_wdata_i;

  two_level_io_request_scheduler u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Shadow copy of the scheduler state
  logic        ent_busy [ENTRIES];
  logic [63:0] ent_off  [ENTRIES];
  logic [63:0] ent_buf  [ENTRIES];
  logic [30:0] ent_id   [ENTRIES];
  logic [31:0] ent_cnt  [ENTRIES];
  logic [7:0]  ent_hdl  [ENTRIES];
  logic [7:0]  ent_gp   [ENTRIES];
  logic [7:0]  ent_rp   [ENTRIES];
  logic        ent_wr   [ENTRIES];
  int          ent_link [ENTRIES];
  int          ent_sub  [ENTRIES];
  int          slot_top [HANDLES];
  int          grp_head;
  logic [30:0] id_ctr;
  logic [30:0] run_id   [RUN_SLOTS];
  logic        run_ok   [RUN_SLOTS];
  logic [5:0]  batch_reg;

  sched_result_t expected_q[$];
  bit  failed;
  bit  idle_on;
  int  hold_left;
  int  cycles;
  int  n_items, n_results, n_dispatched, n_refused;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run-length guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result receiver: random stalls plus forced long hold-offs
  int stall_left;
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (stall_left > 0) stall_left = stall_left - 1;
      else if (idle_on && $urandom_range(0, 5) == 0) stall_left = int'($urandom_range(1, 19));
      m_axis_tready <= (stall_left == 0);
    end
  end

  // Compare each result with the oldest expectation
  always @(negedge clk_i) begin
    sched_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $error("result with no expectation: status %0d", m_axis_tuser);
        failed = 1;
      end else begin
        exp_r = expected_q.pop_front();
        if (m_axis_tuser !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, m_axis_tuser); failed = 1;
        end
        if (m_axis_tdata[30:0] !== exp_r.id) begin
          $error("request_id exp %0d got %0d", exp_r.id, m_axis_tdata[30:0]); failed = 1;
        end
        if (m_axis_tdata[38:31] !== exp_r.hdl) begin
          $error("out_handle exp %0d got %0d", exp_r.hdl, m_axis_tdata[38:31]); failed = 1;
        end
        if (m_axis_tdata[102:39] !== exp_r.off) begin
          $error("out_offset exp %h got %h", exp_r.off, m_axis_tdata[102:39]); failed = 1;
        end
        if (m_axis_tdata[134:103] !== exp_r.cnt) begin
          $error("out_count exp %h got %h", exp_r.cnt, m_axis_tdata[134:103]); failed = 1;
        end
        if (m_axis_tdata[135] !== exp_r.wr) begin
          $error("out_write exp %0d got %0d", exp_r.wr, m_axis_tdata[135]); failed = 1;
        end
        if (m_axis_tdata[199:136] !== exp_r.buff) begin
          $error("out_buffer exp %h got %h", exp_r.buff, m_axis_tdata[199:136]); failed = 1;
        end
        if (m_axis_tlast !== exp_r.last) begin
          $error("last exp %0d got %0d", exp_r.last, m_axis_tlast); failed = 1;
        end
      end
    end
  end

  function automatic void push_result(st_e st, logic [30:0] id, int e, bit with_data);
    sched_result_t r;
    r.status = st;
    r.id     = id;
    r.hdl    = with_data ? ent_hdl[e] : '0;
    r.off    = with_data ? ent_off[e] : '0;
    r.cnt    = with_data ? ent_cnt[e] : '0;
    r.wr     = with_data ? ent_wr[e]  : 1'b0;
    r.buff   = with_data ? ent_buf[e] : '0;
    r.last   = !with_data;
    expected_q.push_back(r);
  endfunction

  function automatic int group_pred(int t);
    int p, c;
    p = NONE;
    c = grp_head;
    while (c != NONE && c != t) begin
      p = c;
      c = ent_link[c];
    end
    return p;
  endfunction

  function automatic void group_swap(int old_t, int new_t);
    int p;
    p = group_pred(old_t);
    ent_link[new_t] = ent_link[old_t];
    if (p == NONE) grp_head = new_t;
    else ent_link[p] = new_t;
  endfunction

  function automatic void release_entry(int e);
    ent_busy[e] = 1'b0;
    ent_link[e] = NONE;
    ent_sub[e]  = NONE;
  endfunction

  function automatic bit is_running(logic [30:0] id);
    for (int i = 0; i < RUN_SLOTS; i++)
      if (run_ok[i] && run_id[i] == id) return 1;
    return 0;
  endfunction

  // Emit one entry as a dispatched result, record its id as running and free it
  function automatic void emit_entry(int e);
    int j;
    push_result(ST_DISPATCHED, ent_id[e], e, 1);
    n_dispatched++;
    j = 0;
    while (j < RUN_SLOTS && run_ok[j]) j++;
    if (j < RUN_SLOTS) begin
      run_ok[j] = 1'b1;
      run_id[j] = ent_id[e];
    end
    release_entry(e);
  endfunction

  // Predict the results of one accepted item and update the shadow state
  function automatic void sched_predict(op_e op, logic [7:0] h, logic [7:0] gp,
                                        logic [7:0] rp, logic [63:0] off,
                                        logic [31:0] cnt, logic wr,
                                        logic [63:0] buff, logic [30:0] tid);
    int e, top, s, p, c, t, nt, ns, k, b;
    case (op)
      OP_SUBMIT: begin
        e = NONE;
        for (int i = 0; i < ENTRIES; i++)
          if (e == NONE && !ent_busy[i]) e = i;
        if (e == NONE) begin
          push_result(ST_REFUSED, '0, 0, 0);
          n_refused++;
        end else begin
          id_ctr = id_ctr + 1'b1;
          ent_busy[e] = 1'b1;
          ent_id[e]   = id_ctr;
          if (id_ctr == ID_TOP) id_ctr = '0;
          ent_off[e] = off;  ent_buf[e] = buff;  ent_cnt[e] = cnt;
          ent_hdl[e] = h;    ent_gp[e]  = gp;    ent_rp[e]  = rp;  ent_wr[e] = wr;
          ent_link[e] = NONE;
          ent_sub[e]  = NONE;
          top = slot_top[h];
          if (top == NONE) begin
            // New handle joins the group list
            slot_top[h] = e;
            if (grp_head == NONE || gp > ent_gp[grp_head]) begin
              ent_link[e] = grp_head;
              grp_head = e;
            end else begin
              c = grp_head;
              while (ent_link[c] != NONE && gp <= ent_gp[ent_link[c]]) c = ent_link[c];
              ent_link[e] = ent_link[c];
              ent_link[c] = e;
            end
          end else if (rp > ent_rp[top]) begin
            // New request takes over the top slot
            ent_gp[e] = ent_gp[top];
            slot_top[h] = e;
            group_swap(top, e);
            ent_sub[e] = top;
            ent_link[top] = ent_sub[top];
            ent_sub[top] = NONE;
          end else begin
            p = NONE;
            c = ent_sub[top];
            while (c != NONE && !(rp > ent_rp[c] || (rp == ent_rp[c] && off < ent_off[c])))
            begin
              p = c;
              c = ent_link[c];
            end
            ent_link[e] = c;
            if (p == NONE) ent_sub[top] = e;
            else ent_link[p] = e;
          end
          push_result(ST_ACCEPTED, ent_id[e], 0, 0);
        end
      end
      OP_CANCEL: begin
        top = slot_top[h];
        if (top != NONE) begin
          if (ent_id[top] == tid) begin
            s = ent_sub[top];
            if (s == NONE) begin
              p = group_pred(top);
              if (p == NONE) grp_head = ent_link[top];
              else ent_link[p] = ent_link[top];
              slot_top[h] = NONE;
            end else begin
              // Promote the sub-queue head with the group priority
              ent_gp[s] = ent_gp[top];
              ent_sub[s] = ent_link[s];
              group_swap(top, s);
              slot_top[h] = s;
            end
            release_entry(top);
          end else begin
            p = NONE;
            c = ent_sub[top];
            while (c != NONE && ent_id[c] != tid) begin
              p = c;
              c = ent_link[c];
            end
            if (c != NONE) begin
              if (p == NONE) ent_sub[top] = ent_link[c];
              else ent_link[p] = ent_link[c];
              release_entry(c);
            end
          end
        end
        push_result(is_running(tid) ? ST_NOT_CANCELLED : ST_CANCELLED, '0, 0, 0);
      end
      OP_DISPATCH: begin
        b = (batch_reg == 0) ? 1 : (batch_reg > 32) ? 32 : int'(batch_reg);
        k = 0;
        t = grp_head;
        while (t != NONE && k < b) begin
          nt = ent_link[t];
          s = ent_sub[t];
          slot_top[ent_hdl[t]] = NONE;
          emit_entry(t);
          k++;
          while (s != NONE && k < ENTRIES) begin
            ns = ent_link[s];
            emit_entry(s);
            k++;
            s = ns;
          end
          t = nt;
        end
        grp_head = t;
        if (k == 0) push_result(ST_EMPTY, '0, 0, 0);
        else expected_q[expected_q.size()-1].last = 1'b1;
      end
      default: begin
        for (int i = 0; i < RUN_SLOTS; i++)
          if (run_ok[i] && run_id[i] == tid) begin
            run_ok[i] = 1'b0;
            break;
          end
      end
    endcase
  endfunction

  // Offer one item, wait for acceptance, then predict
  task automatic send_item(op_e op, logic [7:0] h, logic [7:0] gp, logic [7:0] rp,
                           logic [63:0] off, logic [31:0] cnt, logic wr,
                           logic [63:0] buff, logic [30:0] tid);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {tid, buff, wr, cnt, off, rp, gp, h};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    n_items++;
    sched_predict(op, h, gp, rp, off, cnt, wr, buff, tid);
  endtask

  task automatic submit(logic [7:0] h, logic [7:0] gp, logic [7:0] rp, logic [63:0] off);
    send_item(OP_SUBMIT, h, gp, rp, off, $urandom() | 32'd1, 1'($urandom_range(0, 1)),
              {$urandom(), $urandom()}, '0);
  endtask

  task automatic by_id(op_e op, logic [7:0] h, logic [30:0] tid);
    send_item(op, h, '0, '0, '0, 32'd1, 1'b0, '0, tid);
  endtask

  // Drop valid and hold until all expected results are back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_batch(logic [5:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    batch_reg = v;
  endtask

  task automatic test_directed();
    logic [30:0] hi_id, lo_id;
    by_id(OP_DISPATCH, 8'd0, '0);
    by_id(OP_CANCEL, 8'd7, 31'h7FFF_FFFF);
    by_id(OP_COMPLETE, 8'd0, 31'd1234);
    submit(8'd0, 8'd10, 8'd5, 64'd100);
    submit(8'd0, 8'd99, 8'd5, 64'd50);
    lo_id = id_ctr;
    submit(8'd0, 8'd0, 8'd9, 64'd7);
    hi_id = id_ctr;
    send_item(OP_SUBMIT, 8'd255, 8'd255, 8'd255, '1, '1, 1'b1, '1, '0);
    submit(8'd3, 8'd10, 8'd0, 64'd0);
    submit(8'd0, 8'd200, 8'd0, 64'd0);
    submit(8'd4, 8'd0, 8'd0, '1);
    // Cancel the top of handle 0, then a waiting one, then a lone top
    by_id(OP_CANCEL, 8'd0, hi_id);
    by_id(OP_CANCEL, 8'd0, lo_id);
    by_id(OP_CANCEL, 8'd4, id_ctr);
    by_id(OP_DISPATCH, 8'd0, '0);
    by_id(OP_CANCEL, 8'd0, lo_id - 31'd1);
    by_id(OP_COMPLETE, 8'd0, lo_id - 31'd1);
    by_id(OP_CANCEL, 8'd0, lo_id - 31'd1);
    by_id(OP_DISPATCH, 8'd0, '0);
    by_id(OP_DISPATCH, 8'd0, '0);
  endtask

  // Fill the store past capacity, drain it in one large batch, then refill and drain again
  task automatic test_store_full();
    for (int i = 0; i < ENTRIES + 2; i++)
      submit(8'($urandom_range(0, 5)), 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
             64'($urandom_range(0, 7)));
    write_batch(6'd32);
    by_id(OP_DISPATCH, 8'd0, '0);
    for (int i = 0; i < 6; i++) submit(8'(i), 8'd1, 8'd1, 64'd1);
    by_id(OP_DISPATCH, 8'd0, '0);
  endtask

  // Hold off the receiver while items keep arriving
  task automatic test_backpressure();
    wait_drained();
    hold_left = 600;
    for (int i = 0; i < 12; i++)
      submit(8'($urandom_range(0, 3)), 8'($urandom()), 8'($urandom()), 64'($urandom()));
    by_id(OP_DISPATCH, 8'd0, '0);
    wait_drained();
  endtask

  task automatic random_item();
    int r, e;
    logic [30:0] tid;
    logic [7:0]  h;
    r = int'($urandom_range(0, 99));
    if (r < 45) begin
      if ($urandom_range(0, 4) == 0)
        send_item(OP_SUBMIT, 8'($urandom()), 8'($urandom()), 8'($urandom()),
                  {$urandom(), $urandom()}, $urandom() | 32'd1, 1'($urandom_range(0, 1)),
                  {$urandom(), $urandom()}, '0);
      else
        submit(8'($urandom_range(0, 7)), 8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)),
               ($urandom_range(0, 1) ? 64'($urandom_range(0, 3)) : {$urandom(), $urandom()}));
    end else if (r < 65) begin
      e = int'($urandom_range(0, ENTRIES - 1));
      h = 8'($urandom_range(0, 7));
      tid = 31'($urandom()) | 31'd1;
      if ($urandom_range(0, 2) != 0 && ent_busy[e]) begin
        tid = ent_id[e];
        h = ent_hdl[e];
      end else if ($urandom_range(0, 1) && run_ok[e]) begin
        tid = run_id[e];
      end
      by_id(OP_CANCEL, h, tid);
    end else if (r < 78) begin
      by_id(OP_DISPATCH, 8'($urandom()), '0);
    end else begin
      e = int'($urandom_range(0, RUN_SLOTS - 1));
      tid = run_ok[e] && $urandom_range(0, 3) != 0 ? run_id[e] : (31'($urandom()) | 31'd1);
      by_id(OP_COMPLETE, 8'($urandom()), tid);
    end
  endtask

  task automatic test_random();
    logic [5:0] settings[6] = '{6'd1, 6'd0, 6'd63, 6'd3, 6'd33, 6'd8};
    for (int i = 0; i < 240; i++) begin
      if (i % 40 == 0) write_batch(settings[i / 40]);
      if (i == 190) idle_on = 0;
      random_item();
    end
    write_batch(6'd32);
    by_id(OP_DISPATCH, 8'd0, '0);
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    cycles = 0;
    hold_left = 0;
    stall_left = 0;
    idle_on = 1;
    failed = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      ent_busy[i] = 1'b0;
      ent_link[i] = NONE;
      ent_sub[i] = NONE;
    end
    for (int i = 0; i < HANDLES; i++) slot_top[i] = NONE;
    for (int i = 0; i < RUN_SLOTS; i++) run_ok[i] = 1'b0;
    grp_head = NONE;
    id_ctr = '0;
    batch_reg = BATCH_RESET;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_store_full();
    test_backpressure();
    test_random();
    wait_drained();

    $display("Covered %0d items, %0d results (%0d dispatched, %0d refused)",
             n_items, n_results, n_dispatched, n_refused);
    $display("Batch settings included 0, 1, 32, 33 and 63; receiver hold-off exercised.");
    if (!failed && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
